### sv/bof_pkg.sv
package bof_pkg;

  localparam int unsigned NDIM       = 3;
  localparam int unsigned DIMS_DEF   = 3;
  localparam int unsigned DIV_STAGES = 17;
  // stage A, divider, two multiply stages
  localparam int unsigned LATENCY    = DIV_STAGES + 3;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned FRAC_W     = 17;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  // register indexes (word address)
  localparam logic [2:0] REG_CUT_LOW_0  = 3'd0;
  localparam logic [2:0] REG_CUT_HIGH_0 = 3'd1;
  localparam logic [2:0] REG_CUT_LOW_1  = 3'd2;
  localparam logic [2:0] REG_CUT_HIGH_1 = 3'd3;
  localparam logic [2:0] REG_CUT_LOW_2  = 3'd4;
  localparam logic [2:0] REG_CUT_HIGH_2 = 3'd5;
  localparam logic [2:0] REG_DIMS       = 3'd6;

  typedef struct packed {
    logic signed [31:0] query_low_0;
    logic signed [31:0] query_high_0;
    logic signed [31:0] query_low_1;
    logic signed [31:0] query_high_1;
    logic signed [31:0] query_low_2;
    logic signed [31:0] query_high_2;
  } query_t;

  typedef struct packed {
    logic [FRAC_W-1:0] inside_fraction;
    logic              no_overlap;
  } result_t;

  typedef struct packed {
    logic [31:0]       rem;
    logic [31:0]       rng;
    logic [FRAC_W-1:0] quo;
  } div_stage_t;

  // per-request data that rides beside the divider
  typedef struct packed {
    logic [NDIM-1:0]                use_div;
    logic [NDIM-1:0][FRAC_W-1:0]    fconst;
    logic                           flag;
  } side_t;

endpackage

### sv/bof_div.sv
module bof_div (
  input  logic                       clk_i,
  input  logic [31:0]                dividend_i,
  input  logic [31:0]                divisor_i,
  output logic [bof_pkg::FRAC_W-1:0] quotient_o
);
  import bof_pkg::*;

  // one quotient bit per stage, MSB first; dividend never exceeds divisor
  div_stage_t stage_q [DIV_STAGES];
  div_stage_t stage_d [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        logic ge;
        ge = dividend_i >= divisor_i;
        stage_d[k].rng = divisor_i;
        stage_d[k].rem = ge ? (dividend_i - divisor_i) : dividend_i;
        stage_d[k].quo = {{(FRAC_W-1){1'b0}}, ge};
      end
    end else begin : g_next
      always_comb begin
        logic [32:0] shifted;
        logic [32:0] diff;
        logic        ge;
        shifted = {stage_q[k-1].rem, 1'b0};
        diff    = shifted - {1'b0, stage_q[k-1].rng};
        ge      = shifted >= {1'b0, stage_q[k-1].rng};
        stage_d[k].rng = stage_q[k-1].rng;
        stage_d[k].rem = ge ? diff[31:0] : shifted[31:0];
        stage_d[k].quo = {stage_q[k-1].quo[FRAC_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      stage_q[k] <= stage_d[k];
    end
  end

  assign quotient_o = stage_q[DIV_STAGES-1].quo;

endmodule

### sv/box_overlap_fraction_top.sv
// Channel   | Handshake              | Payload
// request   | start, busy            | query_i  (six Q16.16 edges)
// result    | done_o strobe          | result_o (fraction Q1.16, no_overlap)
// config    | APB psel/penable/pwrite| paddr, pwdata, prdata
//
// One request enters every cycle; busy is never raised.
// From start to result a request passes LATENCY: one clip stage, a
// 17-stage restoring divider (one quotient bit per stage) and two multiply stages.
// Reset clears the valid pipe and loads the cut registers with their defaults.
// The receiver cannot stall; results stream out one per accepted request.
module box_overlap_fraction_top #(
  parameter int unsigned DIMS = bof_pkg::DIMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bof_pkg::query_t            query_i,
  output logic                       done_o,
  output bof_pkg::result_t           result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bof_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bof_pkg::*;

  // ---------------- configuration registers ----------------
  logic [NDIM-1:0][31:0] cut_low_q, cut_low_d;
  logic [NDIM-1:0][31:0] cut_high_q, cut_high_d;
  logic [1:0]            dims_q, dims_d;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // decode register write
  always_comb begin
    cut_low_d  = cut_low_q;
    cut_high_d = cut_high_q;
    dims_d     = dims_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CUT_LOW_0:  cut_low_d[0]  = pwdata;
        REG_CUT_HIGH_0: cut_high_d[0] = pwdata;
        REG_CUT_LOW_1:  cut_low_d[1]  = pwdata;
        REG_CUT_HIGH_1: cut_high_d[1] = pwdata;
        REG_CUT_LOW_2:  cut_low_d[2]  = pwdata;
        REG_CUT_HIGH_2: cut_high_d[2] = pwdata;
        REG_DIMS:       dims_d        = pwdata[1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NDIM; d++) begin
        cut_low_q[d]  <= 32'd0;
        cut_high_q[d] <= 32'h0001_0000;
      end
      dims_q <= 2'd3;
    end else begin
      cut_low_q  <= cut_low_d;
      cut_high_q <= cut_high_d;
      dims_q     <= dims_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_CUT_LOW_0:  prdata = cut_low_q[0];
      REG_CUT_HIGH_0: prdata = cut_high_q[0];
      REG_CUT_LOW_1:  prdata = cut_low_q[1];
      REG_CUT_HIGH_1: prdata = cut_high_q[1];
      REG_CUT_LOW_2:  prdata = cut_low_q[2];
      REG_CUT_HIGH_2: prdata = cut_high_q[2];
      REG_DIMS:       prdata = {30'd0, dims_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- stage A: clip and classify ----------------
  logic [NDIM-1:0][31:0] qlo, qhi;
  logic [1:0]            n_eff;
  side_t                 side_a_d, side_a_q;
  logic [NDIM-1:0][31:0] dvd_d, dvd_q, dvs_d, dvs_q;
  logic                  vld_a_q;

  assign qlo[0] = query_i.query_low_0;
  assign qhi[0] = query_i.query_high_0;
  assign qlo[1] = query_i.query_low_1;
  assign qhi[1] = query_i.query_high_1;
  assign qlo[2] = query_i.query_low_2;
  assign qhi[2] = query_i.query_high_2;

  // clamp dimension count to 1..DIMS
  always_comb begin
    priority if (dims_q == 2'd0)      n_eff = 2'd1;
    else if (dims_q > 2'(DIMS))       n_eff = 2'(DIMS);
    else                              n_eff = dims_q;
  end

  always_comb begin
    side_a_d.flag = 1'b0;
    for (int d = 0; d < NDIM; d++) begin
      logic signed [31:0] lo, hi, clo, chi, ilo, ihi;
      logic signed [32:0] ov, rng;
      logic               used, disj, inv, neg;
      lo   = $signed(qlo[d]);
      hi   = $signed(qhi[d]);
      clo  = $signed(cut_low_q[d]);
      chi  = $signed(cut_high_q[d]);
      ilo  = (clo > lo) ? clo : lo;
      ihi  = (chi < hi) ? chi : hi;
      ov   = {ihi[31], ihi} - {ilo[31], ilo};
      rng  = {hi[31], hi} - {lo[31], lo};
      used = (d < DIMS) && (2'(d) < n_eff);
      disj = (hi < clo) || (lo > chi);
      inv  = hi < lo;
      neg  = ov[32];
      side_a_d.use_div[d] = 1'b0;
      side_a_d.fconst[d]  = ONE_Q16;
      dvd_d[d] = 32'd0;
      dvs_d[d] = 32'd1;
      if (used) begin
        priority if (disj) begin
          side_a_d.fconst[d] = '0;
          side_a_d.flag      = 1'b1;
        end else if (inv) begin
          side_a_d.fconst[d] = '0;
        end else if (neg) begin
          side_a_d.fconst[d] = '0;
          side_a_d.flag      = 1'b1;
        end else if (hi == lo) begin
          side_a_d.fconst[d] = ONE_Q16;
        end else begin
          side_a_d.use_div[d] = 1'b1;
          dvd_d[d] = ov[31:0];
          dvs_d[d] = rng[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_a_q <= side_a_d;
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
  end

  // ---------------- divider lanes ----------------
  logic [NDIM-1:0][FRAC_W-1:0] quo;

  for (genvar d = 0; d < NDIM; d++) begin : g_lane
    if (d < DIMS) begin : g_div
      bof_div u_div (
        .clk_i      (clk_i),
        .dividend_i (dvd_q[d]),
        .divisor_i  (dvs_q[d]),
        .quotient_o (quo[d])
      );
    end else begin : g_none
      assign quo[d] = ONE_Q16;
    end
  end

  // carry sideband and valid alongside the divider
  side_t side_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_a_q;
    for (int k = 1; k < DIV_STAGES; k++) side_q[k] <= side_q[k-1];
  end

  // ---------------- multiply stages ----------------
  logic [NDIM-1:0][FRAC_W-1:0] fac;
  logic [33:0]                 prod1, prod2;
  logic [FRAC_W-1:0]           p1_q, f2_q;
  logic                        flag1_q, vld1_q, vld2_q;
  result_t                     res_q;

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      fac[d] = side_q[DIV_STAGES-1].use_div[d]
             ? ((quo[d] > ONE_Q16) ? ONE_Q16 : quo[d])
             : side_q[DIV_STAGES-1].fconst[d];
    end
  end

  assign prod1 = 34'(fac[0]) * 34'(fac[1]);
  assign prod2 = 34'(p1_q) * 34'(f2_q);

  always_ff @(posedge clk_i) begin
    p1_q    <= prod1[32:16];
    f2_q    <= fac[2];
    flag1_q <= side_q[DIV_STAGES-1].flag;
    res_q.inside_fraction <= prod2[32:16];
    res_q.no_overlap      <= flag1_q;
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_q   <= '0;
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
    end else begin
      vld_a_q <= start;
      vld_q   <= {vld_q[DIV_STAGES-2:0], vld_a_q};
      vld1_q  <= vld_q[DIV_STAGES-1];
      vld2_q  <= vld1_q;
    end
  end

  assign done_o   = vld2_q;
  assign result_o = res_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(LATENCY) done_o)
    else $error("result missing after fixed latency");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.inside_fraction <= ONE_Q16))
    else $error("fraction above one");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.no_overlap |-> (result_o.inside_fraction == '0))
    else $error("flagged result with nonzero fraction");

endmodule
